FILE: hdl/qec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qec_pkg
// Types and constants shared by the quadrature encoder counter modules.
// ----------------------------------------------------------------------------
package qec_pkg;

    localparam int RELOAD_W = 16;
    localparam int FILTER_W = 4;
    localparam int INVERT_W = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'hFFFF;
    localparam logic [FILTER_W-1:0] FILTER_RESET = 4'd8;

    // Register indices, taken from paddr[3:2].
    localparam logic [1:0] REG_RELOAD = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_FILTER = 2'd2;
    localparam logic [1:0] REG_INVERT = 2'd3;

    typedef struct packed {
        logic [RELOAD_W-1:0] reload_value;
        logic                count_enable;
        logic [FILTER_W-1:0] filter_samples;
        logic [INVERT_W-1:0] invert_pins;
    } t_cfg;

    // Filtered level after this sample, and whether it changed on it.
    typedef struct packed {
        logic level;
        logic edge_seen;
    } t_pin_evt;

endpackage : qec_pkg
`default_nettype wire

FILE: hdl/qec_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qec_cfg_regs
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module qec_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [qec_pkg::ADDR_W-1:0] paddr,
    input  wire logic [qec_pkg::DATA_W-1:0] pwdata,
    output logic      [qec_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output qec_pkg::t_cfg                   o_cfg
);
    import qec_pkg::*;

    t_cfg       r_cfg;
    logic       w_write;
    logic [1:0] w_index;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reload_value   <= RELOAD_RESET;
            r_cfg.count_enable   <= 1'b0;
            r_cfg.filter_samples <= FILTER_RESET;
            r_cfg.invert_pins    <= '0;
        end else if (w_write) begin
            unique case (w_index)
                REG_RELOAD: r_cfg.reload_value   <= pwdata[RELOAD_W-1:0];
                REG_ENABLE: r_cfg.count_enable   <= pwdata[0];
                REG_FILTER: r_cfg.filter_samples <= pwdata[FILTER_W-1:0];
                REG_INVERT: r_cfg.invert_pins    <= pwdata[INVERT_W-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_index)
            REG_RELOAD: prdata[RELOAD_W-1:0] = r_cfg.reload_value;
            REG_ENABLE: prdata[0]            = r_cfg.count_enable;
            REG_FILTER: prdata[FILTER_W-1:0] = r_cfg.filter_samples;
            REG_INVERT: prdata[INVERT_W-1:0] = r_cfg.invert_pins;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule : qec_cfg_regs
`default_nettype wire

FILE: hdl/qec_pin_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qec_pin_filter
// Run-length glitch filter for one encoder phase.
// ----------------------------------------------------------------------------
module qec_pin_filter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_sample,
    input  wire logic [qec_pkg::FILTER_W-1:0] i_need,
    output qec_pkg::t_pin_evt                 o_evt
);
    import qec_pkg::*;

    logic                r_level;
    logic [FILTER_W-1:0] r_run;
    logic                n_level;
    logic [FILTER_W-1:0] n_run;
    logic [FILTER_W-1:0] w_need;
    logic [FILTER_W-1:0] w_run_inc;
    logic                w_edge;

    // A filter setting of zero behaves as one.
    assign w_need    = (i_need == '0) ? FILTER_W'(1) : i_need;
    assign w_run_inc = r_run + FILTER_W'(1);

    always_comb begin
        n_level = r_level;
        n_run   = r_run;
        w_edge  = 1'b0;
        if (i_sample == r_level) begin
            n_run = '0;
        end else if (w_run_inc >= w_need) begin
            n_level = i_sample;
            n_run   = '0;
            w_edge  = 1'b1;
        end else begin
            n_run = w_run_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_run   <= '0;
        end else if (i_accept) begin
            r_level <= n_level;
            r_run   <= n_run;
        end
    end

    assign o_evt.level     = n_level;
    assign o_evt.edge_seen = w_edge;

endmodule : qec_pin_filter
`default_nettype wire

FILE: hdl/qec_position.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qec_position
// x4 quadrature decode and wrapping position counter. Its registers are
// also the result register of the block.
// ----------------------------------------------------------------------------
module qec_position #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic                   i_clear,
    input  wire logic                   i_enable,
    input  wire logic [COUNT_WIDTH-1:0] i_top,
    input  wire qec_pkg::t_pin_evt      i_evt_a,
    input  wire qec_pkg::t_pin_evt      i_evt_b,
    output logic                        o_step,
    output logic [COUNT_WIDTH-1:0]      o_position,
    output logic                        o_direction,
    output logic                        o_counted
);
    import qec_pkg::*;

    logic [COUNT_WIDTH-1:0] r_position;
    logic                   r_direction;
    logic                   r_counted;
    logic [COUNT_WIDTH-1:0] n_position;
    logic                   n_direction;
    logic [COUNT_WIDTH-1:0] w_base;
    logic                   w_down;

    // Simultaneous edges on both phases are ambiguous and do not count.
    assign o_step = i_enable & (i_evt_a.edge_seen ^ i_evt_b.edge_seen);
    assign w_base = i_clear ? '0 : r_position;

    always_comb begin
        if (i_evt_a.edge_seen) begin
            w_down = (i_evt_a.level == i_evt_b.level);
        end else begin
            w_down = (i_evt_a.level != i_evt_b.level);
        end
    end

    always_comb begin
        n_position  = w_base;
        n_direction = r_direction;
        if (o_step) begin
            n_direction = w_down;
            if (w_down) begin
                n_position = (w_base == '0) ? i_top : w_base - COUNT_WIDTH'(1);
            end else begin
                n_position = (w_base >= i_top) ? '0 : w_base + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_direction <= 1'b0;
            r_counted   <= 1'b0;
        end else if (i_accept) begin
            r_position  <= n_position;
            r_direction <= n_direction;
            r_counted   <= o_step;
        end
    end

    assign o_position  = r_position;
    assign o_direction = r_direction;
    assign o_counted   = r_counted;

endmodule : qec_position
`default_nettype wire

FILE: hdl/quadrature_encoder_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_encoder_counter_core
// x4 quadrature encoder counter with per-phase glitch filters, pin
// inversion and a position that wraps between zero and a reload value.
//
//   Channel   Direction  Handshake                   Payload
//   sample    in         i_in_valid / o_in_stall     pin_a, pin_b, clear_count
//   result    out        o_out_valid / i_out_stall   position, direction, counted
//   config    in         APB psel/penable/pready     reload, enable, filter, invert
//
// One request is accepted every cycle unless the input is stalled; its result appears in the cycle after.
// The filter, decode and counter update form one registered stage.
// Reset is synchronous and active low and clears all state at once.
// The input stalls only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
module quadrature_encoder_counter_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_pin_a,
    input  wire logic                       i_pin_b,
    input  wire logic                       i_clear_count,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [COUNT_WIDTH-1:0]          o_position,
    output logic                            o_direction,
    output logic                            o_counted,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [qec_pkg::ADDR_W-1:0] paddr,
    input  wire logic [qec_pkg::DATA_W-1:0] pwdata,
    output logic      [qec_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import qec_pkg::*;

    t_cfg     w_cfg;
    t_pin_evt w_evt_a;
    t_pin_evt w_evt_b;
    logic     w_accept;
    logic     w_step;
    logic     r_out_valid;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    qec_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qec_pin_filter u_filter_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sample (i_pin_a ^ w_cfg.invert_pins[0]),
        .i_need   (w_cfg.filter_samples),
        .o_evt    (w_evt_a)
    );

    qec_pin_filter u_filter_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sample (i_pin_b ^ w_cfg.invert_pins[1]),
        .i_need   (w_cfg.filter_samples),
        .o_evt    (w_evt_b)
    );

    qec_position #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_position (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_clear     (i_clear_count),
        .i_enable    (w_cfg.count_enable),
        .i_top       (COUNT_WIDTH'(w_cfg.reload_value)),
        .i_evt_a     (w_evt_a),
        .i_evt_b     (w_evt_b),
        .o_step      (w_step),
        .o_position  (o_position),
        .o_direction (o_direction),
        .o_counted   (o_counted)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted request produced no result");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with an empty result register");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_clear_count && !w_step) |=> (o_position == '0))
        else $error("clear did not zero the position");

    a_direction_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_step) |=> (o_direction == $past(o_direction) && !o_counted))
        else $error("direction changed without a count");

endmodule : quadrature_encoder_counter_core
`default_nettype wire

FILE: tb/sv/tb_quadrature_encoder_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_counter_core
// Self-checking bench for the x4 quadrature counter. A short table of directed
// sample ticks and register writes is followed by random encoder walks under
// several register settings. Every accepted request is run through a local
// model of the filters and the counter; each result is compared with it, or with its row's typed expectation.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_counter_core;
    import qec_pkg::*;

    localparam int CW = 16;

    typedef struct packed {
        logic [CW-1:0] position;
        logic          direction;
        logic          counted;
    } t_tick;

    typedef struct packed {
        logic                level;
        logic                edge_hit;
        logic [FILTER_W-1:0] run;
    } t_filt;

    typedef enum logic {ROW_REG, ROW_TICK} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        a;
        logic        b;
        logic        clr;
        logic        typed;
        t_tick       want;
    } t_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                pin_a     = 1'b0;
    logic                pin_b     = 1'b0;
    logic                clear     = 1'b0;
    logic                out_stall = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic                in_stall;
    logic                out_valid;
    logic [CW-1:0]       position;
    logic                direction;
    logic                counted;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Typed expectation that travels with the request being offered.
    logic                row_typed = 1'b0;
    t_tick               row_want  = '0;

    // Shadow of the registers and the counter state.
    logic [RELOAD_W-1:0] cfg_reload = RELOAD_RESET;
    logic                cfg_enable = 1'b0;
    logic [FILTER_W-1:0] cfg_filter = FILTER_RESET;
    logic [INVERT_W-1:0] cfg_invert = '0;
    logic                lvl_a = 1'b0;
    logic                lvl_b = 1'b0;
    logic [FILTER_W-1:0] run_a = '0;
    logic [FILTER_W-1:0] run_b = '0;
    logic [CW-1:0]       pos   = '0;
    logic                dir   = 1'b0;

    t_tick               pending_ticks [$];
    t_tick               predicted;
    t_tick               got_want;
    t_row                plan [$];
    int                  fail_cnt   = 0;
    int                  idle_pct_s = 29;
    int                  idle_pct_r = 69;
    int                  hold_req   = 0;
    int                  hold_ack   = 0;
    int                  hold_left  = 0;

    quadrature_encoder_counter_core #(
        .COUNT_WIDTH(CW)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_pin_a      (pin_a),
        .i_pin_b      (pin_b),
        .i_clear_count(clear),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_position   (position),
        .o_direction  (direction),
        .o_counted    (counted),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_filt filter_pin(input logic sample, input logic level,
                                         input logic [FILTER_W-1:0] run,
                                         input logic [FILTER_W-1:0] need_cfg);
        t_filt               r;
        logic [FILTER_W-1:0] need;
        // A filter setting of zero behaves as one.
        need       = (need_cfg == '0) ? 4'd1 : need_cfg;
        r.level    = level;
        r.edge_hit = 1'b0;
        r.run      = '0;
        if (sample != level) begin
            r.run = run + 4'd1;
            if (r.run >= need) begin
                r.level    = sample;
                r.run      = '0;
                r.edge_hit = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_tick decode_tick(input logic a_raw, input logic b_raw,
                                          input logic clr);
        t_filt fa;
        t_filt fb;
        logic  down;
        t_tick r;
        fa    = filter_pin(a_raw ^ cfg_invert[0], lvl_a, run_a, cfg_filter);
        fb    = filter_pin(b_raw ^ cfg_invert[1], lvl_b, run_b, cfg_filter);
        lvl_a = fa.level;
        run_a = fa.run;
        lvl_b = fb.level;
        run_b = fb.run;
        if (clr)
            pos = '0;
        r.counted = 1'b0;
        // Both phases moving on one tick is not a valid quadrature step.
        if (cfg_enable && (fa.edge_hit != fb.edge_hit)) begin
            down = fa.edge_hit ? (lvl_a == lvl_b) : (lvl_b != lvl_a);
            if (down)
                pos = (pos == '0) ? cfg_reload : pos - 1'b1;
            else
                pos = (pos >= cfg_reload) ? '0 : pos + 1'b1;
            dir       = down;
            r.counted = 1'b1;
        end
        r.position  = pos;
        r.direction = dir;
        return r;
    endfunction

    // Requests accepted by the block go through the model here.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            predicted = decode_tick(pin_a, pin_b, clear);
            pending_ticks.push_back(row_typed ? row_want : predicted);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_ticks.size() == 0) begin
                $error("result with no request pending: position %0d", position);
                fail_cnt++;
            end else begin
                got_want = pending_ticks.pop_front();
                if (position !== got_want.position) begin
                    $error("position: expected %0d, got %0d", got_want.position, position);
                    fail_cnt++;
                end
                if (direction !== got_want.direction) begin
                    $error("direction: expected %0d, got %0d", got_want.direction,
                           direction);
                    fail_cnt++;
                end
                if (counted !== got_want.counted) begin
                    $error("counted: expected %0d, got %0d", got_want.counted, counted);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver: random stalls, and on request a long hold-off so the block fills.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= 60;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < idle_pct_r);
        end
    end

    function automatic void add_reg(input logic [1:0] idx, input logic [31:0] value);
        t_row r;
        r         = '{kind: ROW_REG, default: '0};
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.value   = value;
        plan.push_back(r);
    endfunction

    function automatic void add_tick(input logic a, input logic b, input logic clr,
                                     input logic typed, input logic [CW-1:0] w_pos,
                                     input logic w_dir, input logic w_cnt);
        t_row r;
        r                = '{kind: ROW_TICK, default: '0};
        r.kind           = ROW_TICK;
        r.a              = a;
        r.b              = b;
        r.clr            = clr;
        r.typed          = typed;
        r.want.position  = w_pos;
        r.want.direction = w_dir;
        r.want.counted   = w_cnt;
        plan.push_back(r);
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RELOAD: cfg_reload = value[RELOAD_W-1:0];
            REG_ENABLE: cfg_enable = value[0];
            REG_FILTER: cfg_filter = value[FILTER_W-1:0];
            REG_INVERT: cfg_invert = value[INVERT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_ticks.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] reload, input logic enable,
                            input logic [3:0] filter, input logic [1:0] invert);
        drain();
        apb_write(REG_RELOAD, {16'd0, reload});
        apb_write(REG_ENABLE, {31'd0, enable});
        apb_write(REG_FILTER, {28'd0, filter});
        apb_write(REG_INVERT, {30'd0, invert});
    endtask

    task automatic send_tick(input logic a, input logic b, input logic clr,
                             input logic typed, input t_tick want);
        if ($urandom_range(99) < idle_pct_s) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_a     <= a;
        pin_b     <= b;
        clear     <= clr;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    // Walks the encoder through Gray steps, each level held long enough to pass
    // the filter, with the odd reversal, double step, glitch and noisy sample.
    task automatic run_random(input int count);
        int         hold;
        int         need;
        int         roll;
        int         k;
        logic [1:0] q;
        logic       fwd;
        logic       ga;
        logic       gb;
        logic       clr;
        need = (cfg_filter == '0) ? 1 : int'(cfg_filter);
        q    = 2'($urandom_range(3));
        fwd  = 1'($urandom_range(1));
        hold = 0;
        for (k = 0; k < count; k++) begin
            if (hold == 0) begin
                roll = $urandom_range(99);
                if (roll < 8)
                    fwd = ~fwd;
                if (roll < 4)
                    q = q + 2'd2;
                else
                    q = fwd ? q + 2'd1 : q - 2'd1;
                hold = $urandom_range(need + 2, need);
            end
            hold--;
            ga   = q[0] ^ q[1];
            gb   = q[1];
            roll = $urandom_range(99);
            if (roll < 5) begin
                if ($urandom_range(1))
                    ga = ~ga;
                else
                    gb = ~gb;
            end else if (roll < 15) begin
                ga = 1'($urandom_range(1));
                gb = 1'($urandom_range(1));
            end
            clr = ($urandom_range(99) < 3);
            send_tick(ga, gb, clr, 1'b0, '0);
        end
    endtask

    initial begin
        int   ph;
        t_row row;

        // After reset, then counting in both directions with the filter at zero.
        add_tick(0, 0, 0, 1, 16'd0, 0, 0);
        add_tick(1, 1, 1, 1, 16'd0, 0, 0);
        add_reg(REG_ENABLE, 1);
        add_reg(REG_FILTER, 0);
        add_tick(1, 0, 0, 0, 0, 0, 0);
        add_tick(1, 1, 0, 0, 0, 0, 0);
        add_tick(0, 1, 0, 0, 0, 0, 0);
        add_tick(0, 0, 0, 0, 0, 0, 0);
        add_tick(0, 1, 0, 0, 0, 0, 0);
        add_tick(1, 0, 0, 0, 0, 0, 0);
        add_tick(1, 0, 1, 0, 0, 0, 0);
        add_tick(0, 0, 0, 1, 16'hFFFF, 1, 1);
        // Position left above a smaller reload value.
        add_reg(REG_RELOAD, 5);
        add_tick(0, 1, 0, 1, 16'hFFFE, 1, 1);
        add_tick(1, 1, 0, 0, 0, 0, 0);
        add_tick(0, 1, 0, 1, 16'd0, 0, 1);
        add_tick(0, 0, 0, 0, 0, 0, 0);
        add_tick(1, 0, 0, 0, 0, 0, 0);
        // A reload of zero still reports a count.
        add_reg(REG_RELOAD, 0);
        add_tick(1, 1, 0, 1, 16'd0, 0, 1);
        add_tick(1, 0, 0, 1, 16'd0, 1, 1);
        // Counting disabled: filters track, clear still acts.
        add_reg(REG_ENABLE, 0);
        add_tick(0, 1, 0, 0, 0, 0, 0);
        add_tick(0, 0, 1, 0, 0, 0, 0);
        // Both pins inverted with a two-sample filter, and a rejected glitch.
        add_reg(REG_INVERT, 3);
        add_reg(REG_FILTER, 2);
        add_reg(REG_RELOAD, 16'hFFFF);
        add_reg(REG_ENABLE, 1);
        add_tick(0, 1, 0, 0, 0, 0, 0);
        add_tick(0, 1, 0, 0, 0, 0, 0);
        add_tick(0, 0, 0, 0, 0, 0, 0);
        add_tick(0, 1, 0, 0, 0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_REG) begin
                drain();
                apb_write(row.reg_idx, row.value);
            end else begin
                send_tick(row.a, row.b, row.clr, row.typed, row.want);
            end
        end

        for (ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_regs(16'hFFFF, 1, 1, 0);
                1: set_regs(16'd5, 1, 2, 1);
                2: set_regs(16'd0, 1, 1, 2);
                3: set_regs(16'd1, 1, 3, 3);
                4: set_regs(16'($urandom), 1, 15, 0);
                5: set_regs(16'($urandom), 0, 4, 1);
                6: set_regs(16'hFFFF, 1, 0, 2);
                7: set_regs(16'($urandom_range(20)), 1, 4'($urandom), 2'($urandom));
                default: set_regs(16'($urandom), 1, 1, 0);
            endcase
            idle_pct_s = (ph < 3) ? 29 : (ph < 6) ? 69 : 0;
            idle_pct_r = (ph < 3) ? 69 : (ph < 6) ? 29 : 0;
            if (ph == 1)
                hold_req <= hold_req + 1;
            if (ph == 4) begin
                run_random(70);
                drain();
                run_random(70);
            end else begin
                run_random(140);
            end
        end

        drain();
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
